[hdl/int_to_radix_digits_top_assert.svh]
// ---------------------------------------------------------------------------
// int_to_radix_digits_top_assert.svh
// Assertion macros shared by the converter RTL.
// ---------------------------------------------------------------------------
`ifndef INT_TO_RADIX_DIGITS_TOP_ASSERT_SVH
`define INT_TO_RADIX_DIGITS_TOP_ASSERT_SVH

// same-cycle implication
`define ITRD_ASSERT_NOW(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("itrd assertion failed");

// next-cycle implication
`define ITRD_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("itrd assertion failed");

`endif

[hdl/itrd_pkg.sv]
// ---------------------------------------------------------------------------
// itrd_pkg
// Shared constants and helpers of the integer to radix digit converter.
// ---------------------------------------------------------------------------
package itrd_pkg;

	localparam int VALUE_BITS_DEF = 31;
	localparam int RADIX_W        = 5;
	localparam int DIGIT_W        = 4;
	localparam int CHAR_W         = 7;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;
	localparam logic [CHAR_W-1:0] CHAR_ALPHA = 7'd55;

	// clamp a written radix into the usable range
	function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		res = r;
		if (r < RADIX_MIN) res = RADIX_MIN;
		else if (r > RADIX_MAX) res = RADIX_MAX;
		return res;
	endfunction

	// ASCII glyph of one digit: '0'-'9', 'A'-'F'
	function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < 4'd10) c = CHAR_ZERO + {3'd0, d};
		else c = CHAR_ALPHA + {3'd0, d};
		return c;
	endfunction

endpackage

[hdl/itrd_ram.sv]
// ---------------------------------------------------------------------------
// itrd_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module itrd_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 31
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/itrd_div.sv]
// ---------------------------------------------------------------------------
// itrd_div
// Bit-serial restoring divider: one quotient bit per cycle, VALUE_BITS
// quotient bits per division, then a one-cycle done pulse.
// ---------------------------------------------------------------------------
module itrd_div #(
	parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [VALUE_BITS-1:0]         dividend,
	input  logic [itrd_pkg::RADIX_W-1:0]  base,
	output logic                          done,
	output logic [VALUE_BITS-1:0]         quotient,
	output logic [itrd_pkg::DIGIT_W-1:0]  remainder
);

	localparam int CNT_W = $clog2(VALUE_BITS + 1);

	logic [VALUE_BITS-1:0]        quo_q;
	logic [itrd_pkg::DIGIT_W-1:0] rem_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         busy_q;
	logic                         done_q;
	logic [itrd_pkg::RADIX_W-1:0] shifted;
	logic [itrd_pkg::RADIX_W-1:0] diff;
	logic                         ge;

	assign shifted = {rem_q, quo_q[VALUE_BITS-1]};
	assign ge      = (shifted >= base);
	assign diff    = shifted - base;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(VALUE_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[VALUE_BITS-2:0], ge};
			rem_q <= ge ? diff[itrd_pkg::DIGIT_W-1:0] : shifted[itrd_pkg::DIGIT_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

[hdl/int_to_radix_digits_top.sv]
// ---------------------------------------------------------------------------
// int_to_radix_digits_top
// Converts an unsigned integer to ASCII digits in a base of 2 to 16,
// most significant digit first, with last set on the final digit.
// ---------------------------------------------------------------------------
// Each digit needs one full pass of the bit-serial divider; the first digit
// leaves only after all digits of the item have been computed.
// One item at a time; each digit leaves through a RAM read (ST_RD), then
// output (ST_OUT), where it waits for out_ready.
// Reset: radix returns to 10, control idles; the digit RAM is not cleared.
module int_to_radix_digits_top #(
	parameter int VALUE_BITS = itrd_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [itrd_pkg::RADIX_W-1:0]  radix,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [VALUE_BITS-1:0]         value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [itrd_pkg::CHAR_W-1:0]   digit_char,
	output logic                          last
);

	localparam int ADDR_W = $clog2(VALUE_BITS);
	localparam int CNT_W  = $clog2(VALUE_BITS + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_RD   = 4'b0100,
		ST_OUT  = 4'b1000
	} state_t;

	state_t                       state_q;
	logic [itrd_pkg::RADIX_W-1:0] base_q;
	logic [CNT_W-1:0]             n_q;
	logic                         div_start;
	logic [VALUE_BITS-1:0]        div_dividend;
	logic                         div_done;
	logic [VALUE_BITS-1:0]        div_quo;
	logic [itrd_pkg::DIGIT_W-1:0] div_rem;
	logic                         quo_zero;
	logic                         ram_we;
	logic                         ram_re;
	logic [itrd_pkg::DIGIT_W-1:0] ram_rdata;
	logic [CNT_W-1:0]             n_dec;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	assign quo_zero     = (div_quo == '0);
	assign div_start    = (in_valid && in_ready) ||
	                      ((state_q == ST_DIV) && div_done && !quo_zero);
	assign div_dividend = (state_q == ST_IDLE) ? value : div_quo;
	assign ram_we       = (state_q == ST_DIV) && div_done;
	assign ram_re       = (state_q == ST_RD);
	assign n_dec        = n_q - 1'b1;

	itrd_div #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.base     (base_q),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	itrd_ram #(
		.WIDTH(itrd_pkg::DIGIT_W),
		.DEPTH(VALUE_BITS)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(n_q[ADDR_W-1:0]),
		.wdata(div_rem),
		.re   (ram_re),
		.raddr(n_dec[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= itrd_pkg::RADIX_RESET;
		end else if (cfg_valid && cfg_ready) begin
			base_q <= itrd_pkg::clamp_radix(radix);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						n_q     <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						n_q <= n_q + 1'b1;
						if (quo_zero) state_q <= ST_RD;
					end
				end
				ST_RD: begin
					n_q     <= n_dec;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= (n_q == '0) ? ST_IDLE : ST_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign digit_char = itrd_pkg::glyph(ram_rdata);
	assign last       = (n_q == '0);

`include "int_to_radix_digits_top_assert.svh"

	`ITRD_ASSERT_NOW(a_store_bound, clk, arst_n, state_q == ST_DIV, n_q < CNT_W'(VALUE_BITS))
	`ITRD_ASSERT_NOW(a_rd_nonempty, clk, arst_n, state_q == ST_RD, n_q != '0)
	`ITRD_ASSERT_NEXT(a_last_idle, clk, arst_n, out_valid && out_ready && last, in_ready)

endmodule
